// ----- rtl/core/kwmh_pkg.sv -----
// kwmh_pkg: shared types, codes and the ordering function for the k-way heap merger
`timescale 1ns / 1ps

package kwmh_pkg;

    // fixed field widths
    localparam int VALUE_BITS = 32;
    localparam int SRC_BITS   = 4;
    localparam int CFG_BITS   = 5;

    // result kind codes
    localparam logic KIND_ELEMENT  = 1'b0;
    localparam logic KIND_FINISHED = 1'b1;

    // input transfer payload
    typedef struct packed {
        logic [SRC_BITS-1:0]          source;
        logic signed [VALUE_BITS-1:0] value;
        logic                         exhausted;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic                         kind;
        logic signed [VALUE_BITS-1:0] value_res;
        logic [SRC_BITS-1:0]          source_res;
    } t_out_item;

    // one heap slot
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [SRC_BITS-1:0]          source;
    } t_entry;

    // datapath micro-operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_PUSH_START,
        OP_UP_RD,
        OP_UP_CMP,
        OP_PHASE,
        OP_POP_RD,
        OP_POP_TOP,
        OP_DN_RD,
        OP_DN_CMP,
        OP_EMIT
    } t_dp_op;

    // datapath status back to the controller
    typedef struct packed {
        logic push_ok;
        logic idx_zero;
        logic up_less;
        logic merging;
        logic load_more;
        logic heap_empty;
        logic dn_done;
        logic out_free;
    } t_dp_status;

    // heap order: smaller signed value first, ties to the lower source
    function automatic logic pair_less(input t_entry a, input t_entry b);
        logic lt;
        if ($signed(a.value) != $signed(b.value)) begin
            lt = $signed(a.value) < $signed(b.value);
        end else begin
            lt = a.source < b.source;
        end
        return lt;
    endfunction

endpackage

// ----- rtl/core/kwmh_datapath.sv -----
// kwmh_datapath: heap memory, sift registers, merge counters and output register
`timescale 1ns / 1ps

module kwmh_datapath #(
    parameter int MAX_SOURCES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kwmh_pkg::t_dp_op                 i_op,
    output kwmh_pkg::t_dp_status             o_status,
    input  kwmh_pkg::t_in_item               i_in_item,
    input  logic                             i_cfg_valid,
    input  logic [kwmh_pkg::CFG_BITS-1:0]    i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output kwmh_pkg::t_out_item              o_out_item
);

    import kwmh_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SOURCES);
    localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
    localparam int IDX_W  = ADDR_W + 2;

    // heap storage and registered read ports
    t_entry r_heap [MAX_SOURCES];
    t_entry r_rd_a;
    t_entry r_rd_b;

    // sift state
    t_entry              r_item;
    logic                r_exhausted;
    logic [ADDR_W-1:0]   r_idx;

    // merge control state
    logic [CNT_W-1:0]    r_count;
    logic [CFG_BITS-1:0] r_loaded;
    logic [CFG_BITS-1:0] r_num_sources;
    logic                r_merging;

    // result staging and output register
    t_out_item           r_res;
    t_out_item           r_out_item;
    logic                r_out_valid;

    logic [CFG_BITS-1:0] eff_sources;
    logic [CFG_BITS:0]   loaded_next;
    logic [ADDR_W-1:0]   parent;
    logic [IDX_W-1:0]    child_l;
    logic [IDX_W-1:0]    child_r;
    logic [CNT_W-1:0]    count_dec;
    logic                l_ok;
    logic                r_ok;
    logic                take_l;
    logic                take_r;
    t_entry              best_lr;
    logic                push_ok;
    logic                up_less;
    logic                out_free;

    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    t_entry              wr_data;

    // source count clamped into the legal range
    always_comb begin
        if (r_num_sources == '0) begin
            eff_sources = CFG_BITS'(1);
        end else if (int'(r_num_sources) > MAX_SOURCES) begin
            eff_sources = CFG_BITS'(MAX_SOURCES);
        end else begin
            eff_sources = r_num_sources;
        end
    end

    // index arithmetic and compares
    assign loaded_next = {1'b0, r_loaded} + (CFG_BITS + 1)'(1);
    assign parent      = (r_idx - ADDR_W'(1)) >> 1;
    assign child_l     = {1'b0, r_idx, 1'b1};
    assign child_r     = child_l + IDX_W'(1);
    assign count_dec   = r_count - CNT_W'(1);
    assign l_ok        = child_l < IDX_W'(r_count);
    assign r_ok        = child_r < IDX_W'(r_count);
    assign take_l      = l_ok && pair_less(r_rd_a, r_item);
    assign best_lr     = take_l ? r_rd_a : r_item;
    assign take_r      = r_ok && pair_less(r_rd_b, best_lr);
    assign push_ok     = !r_exhausted && (r_count < CNT_W'(MAX_SOURCES));
    assign up_less     = pair_less(r_item, r_rd_a);
    assign out_free    = !r_out_valid || !i_out_stall;

    // status to the controller
    always_comb begin
        o_status.push_ok    = push_ok;
        o_status.idx_zero   = (r_idx == '0);
        o_status.up_less    = up_less;
        o_status.merging    = r_merging;
        o_status.load_more  = loaded_next < {1'b0, eff_sources};
        o_status.heap_empty = (r_count == '0);
        o_status.dn_done    = !take_l && !take_r;
        o_status.out_free   = out_free;
    end

    // memory address and write selection
    always_comb begin
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_en     = 1'b0;
        wr_addr   = r_idx;
        wr_data   = r_item;
        case (i_op)
            OP_UP_RD: begin
                rd_addr_a = parent;
                wr_en     = (r_idx == '0);
            end
            OP_UP_CMP: begin
                wr_en   = 1'b1;
                wr_data = up_less ? r_rd_a : r_item;
            end
            OP_POP_RD: begin
                rd_addr_b = count_dec[ADDR_W-1:0];
            end
            OP_DN_RD: begin
                rd_addr_a = child_l[ADDR_W-1:0];
                rd_addr_b = child_r[ADDR_W-1:0];
            end
            OP_DN_CMP: begin
                wr_en   = 1'b1;
                wr_data = take_r ? r_rd_b : best_lr;
            end
            default: begin
            end
        endcase
    end

    // heap memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_heap[wr_addr] <= wr_data;
        end
        r_rd_a <= r_heap[rd_addr_a];
        r_rd_b <= r_heap[rd_addr_b];
    end

    // control state: counts, phase, source count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_loaded      <= '0;
            r_merging     <= 1'b0;
            r_num_sources <= CFG_BITS'(16);
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_num_sources <= i_cfg_data;
            end
            case (i_op)
                OP_PUSH_START: begin
                    if (push_ok) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                OP_PHASE: begin
                    if (!r_merging) begin
                        if (o_status.load_more) begin
                            r_loaded <= loaded_next[CFG_BITS-1:0];
                        end else begin
                            r_merging <= 1'b1;
                        end
                    end
                end
                OP_POP_RD: begin
                    if (r_count == '0) begin
                        r_merging <= 1'b0;
                        r_loaded  <= '0;
                    end else begin
                        r_count <= count_dec;
                    end
                end
                default: begin
                end
            endcase
            if (i_op == OP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_TAKE: begin
                r_item.value  <= i_in_item.value;
                r_item.source <= i_in_item.source;
                r_exhausted   <= i_in_item.exhausted;
            end
            OP_PUSH_START: begin
                r_idx <= r_count[ADDR_W-1:0];
            end
            OP_UP_CMP: begin
                if (up_less) begin
                    r_idx <= parent;
                end
            end
            OP_POP_RD: begin
                if (r_count == '0) begin
                    r_res.kind       <= KIND_FINISHED;
                    r_res.value_res  <= '0;
                    r_res.source_res <= '0;
                end
            end
            OP_POP_TOP: begin
                r_res.kind       <= KIND_ELEMENT;
                r_res.value_res  <= r_rd_a.value;
                r_res.source_res <= r_rd_a.source;
                r_item           <= r_rd_b;
                r_idx            <= '0;
            end
            OP_DN_CMP: begin
                if (take_r) begin
                    r_idx <= child_r[ADDR_W-1:0];
                end else if (take_l) begin
                    r_idx <= child_l[ADDR_W-1:0];
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    r_out_item <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // heap never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SOURCES))
        else $error("heap count above depth");

    // a pop from a non-empty heap removes exactly one entry
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_POP_RD && r_count != '0) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not decrement heap count");

    // a pop of an empty heap stages a finished result and ends the merge
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_POP_RD && r_count == '0) |=> (r_res.kind == KIND_FINISHED && !r_merging))
        else $error("empty pop did not finish the merge");

endmodule

// ----- rtl/core/kwmh_ctrl.sv -----
// kwmh_ctrl: sequencer for load, sift-up push, pop and sift-down of the heap
`timescale 1ns / 1ps

module kwmh_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  kwmh_pkg::t_dp_status i_status,
    output kwmh_pkg::t_dp_op     o_op
);

    import kwmh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_UP_RD,
        S_UP_CMP,
        S_PHASE,
        S_POP_RD,
        S_POP_TOP,
        S_DN_RD,
        S_DN_CMP,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;

    // next state from datapath status
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) begin
                n_state = S_PUSH;
            end
            S_PUSH:    n_state = i_status.push_ok ? S_UP_RD : S_PHASE;
            S_UP_RD:   n_state = i_status.idx_zero ? S_PHASE : S_UP_CMP;
            S_UP_CMP:  n_state = i_status.up_less ? S_UP_RD : S_PHASE;
            S_PHASE: begin
                if (!i_status.merging && i_status.load_more) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_POP_RD;
                end
            end
            S_POP_RD:  n_state = i_status.heap_empty ? S_EMIT : S_POP_TOP;
            S_POP_TOP: n_state = i_status.heap_empty ? S_EMIT : S_DN_RD;
            S_DN_RD:   n_state = S_DN_CMP;
            S_DN_CMP:  n_state = i_status.dn_done ? S_EMIT : S_DN_RD;
            S_EMIT:    if (i_status.out_free) begin
                n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // micro-operation for the current state
    always_comb begin
        case (r_state)
            S_IDLE:    o_op = i_in_valid ? OP_TAKE : OP_NONE;
            S_PUSH:    o_op = OP_PUSH_START;
            S_UP_RD:   o_op = OP_UP_RD;
            S_UP_CMP:  o_op = OP_UP_CMP;
            S_PHASE:   o_op = OP_PHASE;
            S_POP_RD:  o_op = OP_POP_RD;
            S_POP_TOP: o_op = OP_POP_TOP;
            S_DN_RD:   o_op = OP_DN_RD;
            S_DN_CMP:  o_op = OP_DN_CMP;
            S_EMIT:    o_op = OP_EMIT;
            default:   o_op = OP_NONE;
        endcase
    end

    // state and registered input stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

    // stall is low exactly in idle
    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (r_state != S_IDLE))
        else $error("input stall out of step with state");

    // an accepted transfer starts a push
    a_take_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_PUSH && o_in_stall))
        else $error("accepted transfer did not start a push");

    // a result waits while the output register is held
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_status.out_free) |=> (r_state == S_EMIT))
        else $error("result left while output register busy");

endmodule

// ----- rtl/core/kway_min_heap_merger_core.sv -----
// kway_min_heap_merger_core: top level of the k-way merger, sequencer plus heap datapath
// An input transfer is latched, pushed if not exhausted and sifted up level by level; while
// sources still load the next transfer is taken, else the top entry is popped, the last
// entry sinks level by level and the result is staged in the output register. One item at a
// time; input stalls over the sift in the one-write, two-read heap memory and a held output.
// Reset (synchronous, active low): heap empty, load phase, 16 sources, no result pending.
`timescale 1ns / 1ps

module kway_min_heap_merger_core #(
    parameter int MAX_SOURCES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  kwmh_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output kwmh_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kwmh_pkg::CFG_BITS-1:0] i_cfg_data
);

    import kwmh_pkg::*;

    t_dp_op     dp_op;
    t_dp_status dp_status;

    // source count register always takes a write
    assign o_cfg_ready = 1'b1;

    // sequencer
    kwmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_op       (dp_op)
    );

    // heap datapath
    kwmh_datapath #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (dp_op),
        .o_status    (dp_status),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
